// ===== rtl/core/pie_pkg.sv =====
// ----------------------------------------------------------------------------
// pie_pkg
// shared constants for the packet impairment emulator: field widths,
// operation codes, register indexes and arithmetic limits
// ----------------------------------------------------------------------------
package pie_pkg;

   // default depth of the delay queue
   localparam int DELAY_DEPTH_DEF = 16;

   // field widths
   localparam int PCT_W    = 7;
   localparam int COPIES_W = 8;
   localparam int ID_W     = 16;
   localparam int RC_W     = 16;
   localparam int RD_W     = 10;
   localparam int DEN_W    = 9;
   localparam int LHS_W    = 15;
   localparam int CNT_W    = 4;

   // operation codes carried in the request tuser
   localparam logic [1:0] MODE_OFFER = 2'd0;
   localparam logic [1:0] MODE_TICK  = 2'd1;
   localparam logic [1:0] MODE_POLL  = 2'd2;

   // register indexes
   localparam logic [1:0] REG_LOSS      = 2'd0;
   localparam logic [1:0] REG_DELAY     = 2'd1;
   localparam logic [1:0] REG_DUPLICATE = 2'd2;
   localparam logic [1:0] REG_MAX_COPY  = 2'd3;

   // arithmetic limits
   localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
   localparam logic [PCT_W-1:0]  RAND_PCT_MAX = 7'd99;
   localparam logic [DEN_W-1:0]  DEN_MIN      = 9'd100;
   localparam logic [LHS_W-1:0]  PCT_SCALE    = 15'd100;
   localparam logic [RD_W-1:0]   TIMER_RESET  = 10'd1000;
   localparam logic [RD_W-1:0]   DELAY_MAX    = 10'd999;
   localparam logic [CNT_W-1:0]  DIV_LAST     = 4'd15;

endpackage

// ===== rtl/core/packet_impairment_emulator.sv =====
// ----------------------------------------------------------------------------
// packet_impairment_emulator
// decides drop, delay, duplicate or pass for each offered packet, keeps a
// queue of delayed packets and releases them against a millisecond timer
// ----------------------------------------------------------------------------
// One request word is taken at a time; req_tready is high only while the
// sequencer is idle. A tick, a poll and an offer that ends in drop, delay or
// a single send go through accept, band multiply, decide and hand-off to the
// response register; the hand-off waits while that register is full. A
// duplicate adds a modulo step, one quotient bit per cycle through a
// compare-and-subtract unit that forms rand_copies modulo max_copies. The
// response register lets the next word be accepted while the last response
// still waits on rsp_tready; a second response waits in the hand-off step.
// Delayed packets sit in a DELAY_DEPTH entry memory with a registered read
// at the queue head. The queue storage has no reset; only written entries are
// ever returned. Configuration may be written only while the block is idle.
// ----------------------------------------------------------------------------
module packet_impairment_emulator
   import pie_pkg::*;
#(
   parameter int DELAY_DEPTH = DELAY_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   // packet_id[15:0], packet_handle[31:16], rand_percent[38:32],
   // rand_copies[54:39], rand_delay[64:55], zero fill[71:65]
   input  logic [71:0] req_tdata,
   // mode[1:0]
   input  logic [1:0]  req_tuser,
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // copies[7:0], released_id[23:8], released_handle[39:24]
   output logic [39:0] rsp_tdata,
   // was_delayed[0], was_dropped[1], queue_overflow[2], released[3]
   output logic [3:0]  rsp_tuser,
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int PW = (DELAY_DEPTH > 1) ? $clog2(DELAY_DEPTH) : 1;
   localparam int CW = $clog2(DELAY_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(DELAY_DEPTH);
   localparam logic [CW:0]   DEPTH_X = (CW + 1)'(DELAY_DEPTH);
   localparam logic [PW-1:0] HEAD_LAST = PW'(DELAY_DEPTH - 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_DECIDE,
      S_DIV,
      S_DONE
   } state_type;

   // sequencer and configuration
   state_type            state_ff, state_in;
   logic [PCT_W-1:0]     loss_ff, loss_in;
   logic [PCT_W-1:0]     delay_ff, delay_in;
   logic [PCT_W-1:0]     dup_ff, dup_in;
   logic [COPIES_W-1:0]  maxc_ff, maxc_in;

   // captured request word
   logic [1:0]           mode_ff, mode_in;
   logic [ID_W-1:0]      id_ff, id_in;
   logic [ID_W-1:0]      handle_ff, handle_in;
   logic [PCT_W-1:0]     d_ff, d_in;
   logic [DEN_W-1:0]     den_ff, den_in;
   logic [RC_W-1:0]      rc_ff, rc_in;
   logic [RD_W-1:0]      rdly_ff, rdly_in;

   // band product and modulo unit
   logic [LHS_W-1:0]     lhs_ff, lhs_in;
   logic [COPIES_W-1:0]  rem_ff, rem_in;
   logic [COPIES_W-1:0]  mod_ff, mod_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   // queue and timer
   logic [PW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [RD_W-1:0]      timer_ff, timer_in;

   // result waiting for the response register
   logic [COPIES_W-1:0]  res_copies_ff, res_copies_in;
   logic [3:0]           res_user_ff, res_user_in;
   logic [ID_W-1:0]      res_rid_ff, res_rid_in;
   logic [ID_W-1:0]      res_rhandle_ff, res_rhandle_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [39:0]          rsp_data_ff, rsp_data_in;
   logic [3:0]           rsp_user_ff, rsp_user_in;

   // queue memory, {handle, id} per entry
   logic [2*ID_W-1:0]    queue_mem_ff [DELAY_DEPTH];
   logic [2*ID_W-1:0]    queue_rd_ff;
   logic                 mem_we;
   logic [PW-1:0]        mem_waddr;
   logic [2*ID_W-1:0]    mem_wdata;

   // datapath helpers
   logic [PCT_W-1:0]     rp_clamp;
   logic [DEN_W-1:0]     total_now;
   logic [PCT_W-1:0]     wr_clamp;
   logic [LHS_W-1:0]     mul_full;
   logic [LHS_W-1:0]     band_loss, band_delay, band_dup;
   logic [CW:0]          tail_sum;
   logic [PW-1:0]        tail;
   logic [COPIES_W:0]    div_trial;
   logic [COPIES_W-1:0]  div_rem;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // percent sum spans the three bands
   assign total_now = DEN_W'(loss_ff) + DEN_W'(delay_ff) + DEN_W'(dup_ff);
   assign rp_clamp  = (req_tdata[38:32] > RAND_PCT_MAX) ? RAND_PCT_MAX : req_tdata[38:32];
   assign wr_clamp  = (csr_wdata[6:0] > PCT_FULL) ? PCT_FULL : csr_wdata[6:0];

   // d * den, at most 100 * 300
   assign mul_full = LHS_W'(d_ff) * LHS_W'(den_ff);

   // cumulative band ends scaled by 100
   assign band_loss  = LHS_W'(loss_ff) * PCT_SCALE;
   assign band_delay = (LHS_W'(loss_ff) + LHS_W'(delay_ff)) * PCT_SCALE;
   assign band_dup   = LHS_W'(total_now) * PCT_SCALE;

   // tail slot wraps at the queue depth
   assign tail_sum = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
   assign tail     = (tail_sum >= DEPTH_X) ? PW'(tail_sum - DEPTH_X) : PW'(tail_sum);

   // one restoring modulo step: shift in the next bit, subtract if it fits
   assign div_trial = {rem_ff, rc_ff[RC_W-1]};
   assign div_rem   = (div_trial >= {1'b0, mod_ff}) ? COPIES_W'(div_trial - {1'b0, mod_ff})
                                                    : div_trial[COPIES_W-1:0];

   always_comb begin
      state_in       = state_ff;
      loss_in        = loss_ff;
      delay_in       = delay_ff;
      dup_in         = dup_ff;
      maxc_in        = maxc_ff;
      mode_in        = mode_ff;
      id_in          = id_ff;
      handle_in      = handle_ff;
      d_in           = d_ff;
      den_in         = den_ff;
      rc_in          = rc_ff;
      rdly_in        = rdly_ff;
      lhs_in         = lhs_ff;
      rem_in         = rem_ff;
      mod_in         = mod_ff;
      cnt_in         = cnt_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      timer_in       = timer_ff;
      res_copies_in  = res_copies_ff;
      res_user_in    = res_user_ff;
      res_rid_in     = res_rid_ff;
      res_rhandle_in = res_rhandle_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      mem_we         = 1'b0;
      mem_waddr      = tail;
      mem_wdata      = {handle_ff, id_ff};

      // register writes; the user must write only while idle, the block does not enforce it
      if (csr_we) begin
         case (csr_index)
            REG_LOSS:      loss_in  = wr_clamp;
            REG_DELAY:     delay_in = wr_clamp;
            REG_DUPLICATE: dup_in   = wr_clamp;
            REG_MAX_COPY:  maxc_in  = csr_wdata;
            default:       ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               mode_in   = req_tuser;
               id_in     = req_tdata[15:0];
               handle_in = req_tdata[31:16];
               d_in      = rp_clamp + 7'd1;
               den_in    = (total_now > DEN_MIN) ? total_now : DEN_MIN;
               rc_in     = req_tdata[54:39];
               rdly_in   = req_tdata[64:55];
               state_in  = S_MUL;
            end
         end

         S_MUL: begin
            lhs_in   = mul_full;
            state_in = S_DECIDE;
         end

         S_DECIDE: begin
            res_copies_in  = '0;
            res_user_in    = '0;
            res_rid_in     = '0;
            res_rhandle_in = '0;
            state_in       = S_DONE;
            case (mode_ff)
               MODE_OFFER: begin
                  if (lhs_ff <= band_loss) begin
                     res_user_in[1] = 1'b1;
                  end else if (lhs_ff <= band_delay) begin
                     if (count_ff < DEPTH_C) begin
                        mem_we         = 1'b1;
                        count_in       = count_ff + 1'b1;
                        res_user_in[0] = 1'b1;
                     end else begin
                        // queue full: drop and flag it
                        res_user_in[1] = 1'b1;
                        res_user_in[2] = 1'b1;
                     end
                  end else if (lhs_ff <= band_dup) begin
                     // zero max_copies acts as one
                     mod_in   = (maxc_ff == '0) ? COPIES_W'(1) : maxc_ff;
                     rem_in   = '0;
                     cnt_in   = '0;
                     state_in = S_DIV;
                  end else begin
                     res_copies_in = COPIES_W'(1);
                  end
               end
               MODE_TICK: begin
                  if (timer_ff != '0) begin
                     timer_in = timer_ff - 1'b1;
                  end
               end
               MODE_POLL: begin
                  if (count_ff != '0 && timer_ff == '0) begin
                     res_user_in[3] = 1'b1;
                     res_rid_in     = queue_rd_ff[ID_W-1:0];
                     res_rhandle_in = queue_rd_ff[2*ID_W-1:ID_W];
                     head_in        = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
                     count_in       = count_ff - 1'b1;
                     timer_in       = (rdly_ff > DELAY_MAX) ? DELAY_MAX : rdly_ff;
                  end
               end
               default: ;
            endcase
         end

         S_DIV: begin
            rem_in = div_rem;
            rc_in  = {rc_ff[RC_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               res_copies_in = div_rem + 1'b1;
               state_in      = S_DONE;
            end
         end

         S_DONE: begin
            // hand off once the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_rhandle_ff, res_rid_ff, res_copies_ff};
               rsp_user_in  = res_user_ff;
               state_in     = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loss_ff      <= '0;
         delay_ff     <= '0;
         dup_ff       <= '0;
         maxc_ff      <= COPIES_W'(1);
         head_ff      <= '0;
         count_ff     <= '0;
         timer_ff     <= TIMER_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         loss_ff      <= loss_in;
         delay_ff     <= delay_in;
         dup_ff       <= dup_in;
         maxc_ff      <= maxc_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         timer_ff     <= timer_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff        <= mode_in;
      id_ff          <= id_in;
      handle_ff      <= handle_in;
      d_ff           <= d_in;
      den_ff         <= den_in;
      rc_ff          <= rc_in;
      rdly_ff        <= rdly_in;
      lhs_ff         <= lhs_in;
      rem_ff         <= rem_in;
      mod_ff         <= mod_in;
      cnt_ff         <= cnt_in;
      res_copies_ff  <= res_copies_in;
      res_user_ff    <= res_user_in;
      res_rid_ff     <= res_rid_in;
      res_rhandle_ff <= res_rhandle_in;
      rsp_data_ff    <= rsp_data_in;
      rsp_user_ff    <= rsp_user_in;
   end

   // queue memory: one write port at the tail, registered read at the head
   always_ff @(posedge clock) begin
      if (mem_we) begin
         queue_mem_ff[mem_waddr] <= mem_wdata;
      end
      queue_rd_ff <= queue_mem_ff[head_ff];
   end

   // queue fill never exceeds its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C)
      else $error("delay queue count above depth");

   // a queue write grows the fill by exactly one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      mem_we |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue write without count increment");

   // delay, drop and release outcomes exclude each other; overflow comes with drop
   a_flag_mix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_user_ff[0] && rsp_user_ff[1])
                       && (!rsp_user_ff[2] || rsp_user_ff[1])
                       && (!rsp_user_ff[3] || rsp_user_ff[2:0] == 3'b000))
      else $error("conflicting response flags");

   // packets sent now only when no other outcome applies
   a_copies_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff[7:0] != '0) |-> rsp_user_ff == 4'b0000)
      else $error("copies reported with an impairment flag");

   // the release timer never exceeds its reset value
   a_timer_bound: assert property (@(posedge clock) disable iff (reset)
      timer_ff <= TIMER_RESET)
      else $error("release timer out of range");

endmodule

// ===== sim/tb_packet_impairment_emulator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_packet_impairment_emulator
// self-checking bench: directed and random request words drive the emulator,
// a local predictor of the drop / delay / duplicate / release decisions and
// of the delay queue and release timer works out each response word, and a
// monitor compares every accepted response with the oldest prediction
// ----------------------------------------------------------------------------
module tb_packet_impairment_emulator;
   import pie_pkg::*;

   // mode 3 has no operation behind it, the block answers with all zeros
   localparam logic [1:0] MODE_NONE = 2'd3;

   localparam int IDLE_PCT    = 9;        // chance of a gap per cycle, each side
   localparam int HOLD_CYCLES = 300;      // long receiver hold-off
   localparam int RANDOM_WORDS = 92;      // random words per setting
   localparam int CYCLE_LIMIT = 600000;

   // one request word, fields as carried on req_tdata / req_tuser
   typedef struct packed {
      logic [1:0]          mode;
      logic [ID_W-1:0]     id;
      logic [ID_W-1:0]     handle;
      logic [PCT_W-1:0]    rp;
      logic [RC_W-1:0]     rc;
      logic [RD_W-1:0]     rd;
   } word_type;

   // one response word
   typedef struct packed {
      logic [COPIES_W-1:0] copies;
      logic                delayed;
      logic                dropped;
      logic                overflow;
      logic                released;
      logic [ID_W-1:0]     rel_id;
      logic [ID_W-1:0]     rel_handle;
   } verdict_type;

   // block ports, every input known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = '0;
   logic [7:0]  csr_wdata = '0;

   // stimulus and scoreboard
   word_type    pending_words[$];
   verdict_type awaited_verdicts[$];
   word_type    offered_word = '0;
   word_type    staged_word;
   verdict_type seen_verdict;
   verdict_type due_verdict;
   int          fail_count = 0;
   int          rsp_count = 0;
   int          cycle_count = 0;
   logic        no_idle = 1'b0;
   logic        hold_rsp = 1'b0;
   logic        hold_armed = 1'b0;

   // predictor copy of the register file
   logic [PCT_W-1:0]    cfg_loss = '0;
   logic [PCT_W-1:0]    cfg_delay = '0;
   logic [PCT_W-1:0]    cfg_dup = '0;
   logic [COPIES_W-1:0] cfg_max_copies = 8'd1;

   // predictor copy of the delay queue and the millisecond release timer
   logic [ID_W-1:0]     fifo_ids[DELAY_DEPTH_DEF];
   logic [ID_W-1:0]     fifo_handles[DELAY_DEPTH_DEF];
   logic [CNT_W-1:0]    fifo_head = '0;
   logic [CNT_W:0]      fifo_count = '0;
   logic [RD_W-1:0]     ms_timer = TIMER_RESET;

   packet_impairment_emulator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // word queue and prediction queue helpers
   function automatic void add_word(input word_type w);
      pending_words = {pending_words, w};
   endfunction

   function automatic word_type take_word();
      word_type w;
      w = pending_words[0];
      pending_words.delete(0);
      return w;
   endfunction

   function automatic void note_verdict(input verdict_type v);
      awaited_verdicts = {awaited_verdicts, v};
   endfunction

   function automatic verdict_type take_verdict();
      verdict_type v;
      v = awaited_verdicts[0];
      awaited_verdicts.delete(0);
      return v;
   endfunction

   // decision for one accepted word; updates the queue and timer copies
   function automatic verdict_type judge_word(input word_type w);
      verdict_type         v;
      logic [PCT_W-1:0]    d;
      logic [DEN_W-1:0]    total;
      logic [DEN_W-1:0]    den;
      logic [LHS_W-1:0]    lhs;
      logic [COPIES_W-1:0] m;
      logic [CNT_W-1:0]    slot;
      v = '0;
      case (w.mode)
         MODE_OFFER: begin
            // band select value 1..100, out-of-range random percent saturates
            d = ((w.rp > RAND_PCT_MAX) ? RAND_PCT_MAX : w.rp) + 7'd1;
            total = DEN_W'(cfg_loss) + DEN_W'(cfg_delay) + DEN_W'(cfg_dup);
            // scale bands down when the three percentages exceed 100
            den = (total > DEN_MIN) ? total : DEN_MIN;
            lhs = LHS_W'(d) * LHS_W'(den);
            if (lhs <= PCT_SCALE * LHS_W'(cfg_loss)) begin
               v.dropped = 1'b1;
            end else if (lhs <= PCT_SCALE * (LHS_W'(cfg_loss) + LHS_W'(cfg_delay))) begin
               if (fifo_count < DELAY_DEPTH_DEF) begin
                  slot = fifo_head + fifo_count[CNT_W-1:0];
                  fifo_ids[slot] = w.id;
                  fifo_handles[slot] = w.handle;
                  fifo_count = fifo_count + 1'b1;
                  v.delayed = 1'b1;
               end else begin
                  // delay chosen but no room: dropped and flagged
                  v.dropped = 1'b1;
                  v.overflow = 1'b1;
               end
            end else if (lhs <= PCT_SCALE * LHS_W'(total)) begin
               // zero max copies acts as one
               m = (cfg_max_copies == '0) ? 8'd1 : cfg_max_copies;
               v.copies = COPIES_W'((w.rc % m) + 1'b1);
            end else begin
               v.copies = 8'd1;
            end
         end
         MODE_TICK: begin
            // timer stops at zero
            if (ms_timer != '0) ms_timer = ms_timer - 1'b1;
         end
         MODE_POLL: begin
            // release only with a queued packet and an expired timer
            if (fifo_count != '0 && ms_timer == '0) begin
               slot = fifo_head;
               v.released = 1'b1;
               v.rel_id = fifo_ids[slot];
               v.rel_handle = fifo_handles[slot];
               fifo_head = fifo_head + 1'b1;
               fifo_count = fifo_count - 1'b1;
               ms_timer = (w.rd > DELAY_MAX) ? DELAY_MAX : w.rd;
            end
         end
         default: begin
         end
      endcase
      return v;
   endfunction

   function automatic word_type build_word(input logic [1:0] mode, input logic [15:0] id,
                                           input logic [15:0] handle, input logic [6:0] rp,
                                           input logic [15:0] rc, input logic [9:0] rd);
      word_type w;
      w.mode = mode;
      w.id = id;
      w.handle = handle;
      w.rp = rp;
      w.rc = rc;
      w.rd = rd;
      return w;
   endfunction

   // random word: mostly offers, then ticks and polls, a few unused modes
   function automatic word_type random_word();
      word_type w;
      int       sel;
      sel = $urandom_range(0, 99);
      if (sel < 50) w.mode = MODE_OFFER;
      else if (sel < 72) w.mode = MODE_TICK;
      else if (sel < 95) w.mode = MODE_POLL;
      else w.mode = MODE_NONE;
      w.id = ID_W'($urandom);
      w.handle = ID_W'($urandom);
      w.rc = RC_W'($urandom);
      if ($urandom_range(0, 9) == 0) w.rp = PCT_W'($urandom_range(100, 127));
      else w.rp = PCT_W'($urandom_range(0, 99));
      // short reloads on polls keep releases flowing; full range elsewhere
      if (w.mode == MODE_POLL) begin
         if ($urandom_range(0, 19) == 0) w.rd = RD_W'($urandom_range(4, 40));
         else w.rd = RD_W'($urandom_range(0, 3));
      end else begin
         w.rd = RD_W'($urandom_range(0, 1023));
      end
      return w;
   endfunction

   // one register write, mirrored into the predictor once it has landed
   task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_LOSS:      cfg_loss  = (value[6:0] > PCT_FULL) ? PCT_FULL : value[6:0];
         REG_DELAY:     cfg_delay = (value[6:0] > PCT_FULL) ? PCT_FULL : value[6:0];
         REG_DUPLICATE: cfg_dup   = (value[6:0] > PCT_FULL) ? PCT_FULL : value[6:0];
         REG_MAX_COPY:  cfg_max_copies = value;
         default: begin
         end
      endcase
   endtask

   task automatic program_regs(input logic [7:0] loss, input logic [7:0] delay,
                               input logic [7:0] dup, input logic [7:0] max_copies);
      write_reg(REG_LOSS, loss);
      write_reg(REG_DELAY, delay);
      write_reg(REG_DUPLICATE, dup);
      write_reg(REG_MAX_COPY, max_copies);
   endtask

   // block is idle once every word is sent and every response is back;
   // sampled on the falling edge so the driver's updates have settled
   task automatic wait_quiet();
      while (pending_words.size() != 0 || req_tvalid || awaited_verdicts.size() != 0)
         @(negedge clock);
      // margin past the sequencer's last step
      repeat (6) @(posedge clock);
   endtask

   // request driver: holds a word until it is taken, then maybe a gap
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            note_verdict(judge_word(offered_word));
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
               staged_word = take_word();
               offered_word <= staged_word;
               req_tdata <= {7'd0, staged_word.rd, staged_word.rc, staged_word.rp,
                             staged_word.handle, staged_word.id};
               req_tuser <= staged_word.mode;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready: random stalls, or held low during the hold-off
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_rsp && (no_idle || $urandom_range(0, 99) >= IDLE_PCT);
   end

   // long hold-off on the response side, counted here in cycles
   initial begin
      wait (hold_armed);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen_verdict.copies     = rsp_tdata[7:0];
         seen_verdict.rel_id     = rsp_tdata[23:8];
         seen_verdict.rel_handle = rsp_tdata[39:24];
         seen_verdict.delayed    = rsp_tuser[0];
         seen_verdict.dropped    = rsp_tuser[1];
         seen_verdict.overflow   = rsp_tuser[2];
         seen_verdict.released   = rsp_tuser[3];
         if (awaited_verdicts.size() == 0) begin
            fail_count++;
            if (fail_count <= 20)
               $display("%0t: unexpected response word %h", $time, seen_verdict);
         end else begin
            due_verdict = take_verdict();
            if (seen_verdict !== due_verdict) begin
               fail_count++;
               if (fail_count <= 20)
                  $display({"%0t: word %0d expected copies=%0d dly=%b drop=%b ovf=%b ",
                            "rel=%b id=%h hdl=%h, got copies=%0d dly=%b drop=%b ovf=%b ",
                            "rel=%b id=%h hdl=%h"},
                           $time, rsp_count,
                           due_verdict.copies, due_verdict.delayed, due_verdict.dropped,
                           due_verdict.overflow, due_verdict.released,
                           due_verdict.rel_id, due_verdict.rel_handle,
                           seen_verdict.copies, seen_verdict.delayed,
                           seen_verdict.dropped, seen_verdict.overflow,
                           seen_verdict.released, seen_verdict.rel_id,
                           seen_verdict.rel_handle);
            end
         end
         rsp_count++;
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d responses still awaited", $time,
                  awaited_verdicts.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // reset, then the stimulus phases
   initial begin
      logic [7:0] loss, delay, dup, maxc;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: everything passes once; field extremes, every mode,
      // saturated random percent, poll on an empty queue with timer running
      add_word(build_word(MODE_OFFER, 16'h0000, 16'h0000, 7'd0, 16'h0000, 10'd0));
      add_word(build_word(MODE_OFFER, 16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 10'h3FF));
      add_word(build_word(MODE_TICK, 16'h1234, 16'h5678, 7'd50, 16'h0, 10'd7));
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'd5));
      add_word(build_word(MODE_NONE, 16'hFFFF, 16'hFFFF, 7'h7F, 16'hFFFF, 10'h3FF));
      wait_quiet();

      // every offer is delayed: fill the queue, then one more overflows;
      // zero max copies is written here too
      program_regs(8'd0, 8'd100, 8'd0, 8'd0);
      for (int i = 0; i < DELAY_DEPTH_DEF + 1; i++)
         add_word(build_word(MODE_OFFER, ID_W'(16'hA500 + i), ~ID_W'(16'hA500 + i),
                             PCT_W'($urandom_range(0, 99)), RC_W'($urandom), 10'd0));
      // poll on a full queue while the timer still runs
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'd0));
      // run the timer out, then tick twice more at zero
      repeat (1001)
         add_word(build_word(MODE_TICK, ID_W'($urandom), ID_W'($urandom), 7'd0, 16'h0,
                             10'd0));
      // release with a zero reload, then again with a short reload
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'd0));
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'd2));
      wait_quiet();

      // random phases over a spread of settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin loss = 8'd30;  delay = 8'd30;  dup = 8'd30;  maxc = 8'd4;   end
            1: begin loss = 8'd0;   delay = 8'd0;   dup = 8'd100; maxc = 8'd255; end
            // over-range writes clamp, sum of 300 scales the bands
            2: begin loss = 8'hFF;  delay = 8'd100; dup = 8'd100; maxc = 8'd3;   end
            // top bit of the write is outside the 7-bit field
            3: begin loss = 8'h80;  delay = 8'd40;  dup = 8'd60;  maxc = 8'd0;   end
            4: begin
               loss = 8'($urandom_range(0, 255));
               delay = 8'($urandom_range(0, 255));
               dup = 8'($urandom_range(0, 255));
               maxc = 8'($urandom_range(0, 255));
            end
            default: begin loss = 8'd10; delay = 8'd50; dup = 8'd20; maxc = 8'd7; end
         endcase
         program_regs(loss, delay, dup, maxc);
         // receiver stalls long enough to back the block up into req_tready
         if (ph == 0) hold_armed = 1'b1;
         // a stretch with no gaps on either side
         if (ph == 5) no_idle <= 1'b1;
         if (ph == 1) begin
            // largest copy count, and a modulo that wraps back to one copy
            add_word(build_word(MODE_OFFER, 16'h00FE, 16'h0, 7'd99, 16'd254, 10'd0));
            add_word(build_word(MODE_OFFER, 16'hFFFF, 16'h0, 7'd0, 16'hFFFF, 10'd0));
         end
         repeat (RANDOM_WORDS) add_word(random_word());
         wait_quiet();
         no_idle <= 1'b0;
      end

      // reload above 999 saturates: queue one packet, run the short timer
      // out, release with the largest reload, then a poll finds it running
      program_regs(8'd0, 8'd100, 8'd0, 8'd1);
      add_word(build_word(MODE_OFFER, 16'h5A5A, 16'hA5A5, 7'd0, 16'h0, 10'd0));
      repeat (41)
         add_word(build_word(MODE_TICK, 16'h0, 16'h0, 7'd0, 16'h0, 10'd0));
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'h3FF));
      add_word(build_word(MODE_POLL, 16'h0, 16'h0, 7'd0, 16'h0, 10'd0));
      wait_quiet();

      repeat (20) @(posedge clock);
      if (fail_count == 0 && awaited_verdicts.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/pie_pkg.sv
rtl/core/packet_impairment_emulator.sv
sim/tb_packet_impairment_emulator.sv
